/* rtl/assert_macros.svh */
// Assertion macros used by the verification checker of the deframer.
// No dependencies; included by the checker file only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with the usual reset qualification.
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsd assertion failed");

// A signal holds its value in the cycle after the condition.
`define WSD_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("wsd hold assertion failed");

`endif

/* rtl/wsd_pkg.sv */
// Package of the WebSocket frame deframer: widths, constants and the result type.
// No dependencies; imported by every RTL module of the block but the input register.
package wsd_pkg;

    localparam int LEN_W = 63;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    typedef struct packed {
        logic             is_header;
        logic             fin;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] body_length;
        logic [7:0]       out_byte;
        logic             last;
    } res_t;

endpackage

/* rtl/wsd_intf.sv */
// Channel interfaces of the deframer: received bytes in, frame results out.
// Depends on wsd_pkg for the length width.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface wsd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        is_header;
    logic                        fin;
    logic [3:0]                  opcode;
    logic                        masked;
    logic [wsd_pkg::LEN_W-1:0]   body_length;
    logic [7:0]                  out_byte;
    logic                        last;

    modport source (output valid, output is_header, output fin, output opcode,
                    output masked, output body_length, output out_byte,
                    output last, input ready);
    modport sink (input valid, input is_header, input fin, input opcode,
                  input masked, input body_length, input out_byte,
                  input last, output ready);
    modport monitor (input valid, input ready, input is_header, input fin,
                     input opcode, input masked, input body_length,
                     input out_byte, input last);
endinterface

/* rtl/websocket_frame_deframer_core.sv */
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_intf, wsd_in_stage, wsd_parser and wsd_out_stage.
//
//   Channel     Direction  Request
//   byte_ch     in         one received byte of the frame stream
//   result_ch   out        one header result or one unmasked payload byte
//
// One byte is accepted per cycle while result_ch does not stall; a result passes the input and result registers.
// The parser steps only when the result register can take its output, which sets the rate.
// Reset clears the parser state and both valid flags; the next byte starts a frame.
// A stall on result_ch backs up through the input register to byte_ch.ready.
module websocket_frame_deframer_core (
    input  logic      clk,
    input  logic      rst_n,
    wsd_in_if.sink    byte_ch,
    wsd_out_if.source result_ch
);
    import wsd_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       step;
    logic       res_valid;
    logic       load_ready;
    res_t       res;

    assign step = byte_valid && load_ready;

    wsd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .take       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (res_valid),
        .load_res   (res),
        .load_ready (load_ready),
        .result_ch  (result_ch)
    );
endmodule

/* rtl/wsd_in_stage.sv */
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on wsd_in_if.
module wsd_in_stage (
    input  logic     clk,
    input  logic     rst_n,
    wsd_in_if.sink   byte_ch,
    input  logic     take,
    output logic     byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign byte_ch.ready = !valid_reg || take;
    assign byte_valid    = valid_reg;
    assign byte_data     = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_ch.ready)
        begin
            valid_next = byte_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            data_reg <= byte_ch.data_byte;
        end
    end
endmodule

/* rtl/wsd_parser.sv */
// Frame header parser and payload unmasking, one byte per step.
// Depends on wsd_pkg.
module wsd_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data_byte,
    output logic          res_valid,
    output wsd_pkg::res_t res
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       hdr_cnt_reg, hdr_cnt_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             mask_reg, mask_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      key_reg, key_next;
    logic [1:0]       key_idx_reg, key_idx_next;
    logic [LEN_W-1:0] remain_reg, remain_next;

    logic       emit;
    logic       hdr;
    logic       lst;
    logic       after_len;
    logic       finish;
    logic [7:0] key_byte;
    logic [7:0] obyte;

    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        key_idx_next = key_idx_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        hdr          = 1'b0;
        lst          = 1'b0;
        obyte        = 8'd0;
        after_len    = 1'b0;
        finish       = 1'b0;

        unique case (phase_reg)
            PH_BYTE0:
            begin
                fin_next    = data_byte[7];
                opcode_next = data_byte[3:0];
                phase_next  = PH_BYTE1;
            end
            PH_BYTE1:
            begin
                mask_next    = data_byte[7];
                key_next     = 32'd0;
                hdr_cnt_next = 3'd0;
                if (data_byte[6:0] == LEN_CODE_EXT16)
                begin
                    len_next   = '0;
                    phase_next = PH_EXT16;
                end
                else if (data_byte[6:0] == LEN_CODE_EXT64)
                begin
                    len_next   = '0;
                    phase_next = PH_EXT64;
                end
                else
                begin
                    len_next  = {{(LEN_W-7){1'b0}}, data_byte[6:0]};
                    after_len = 1'b1;
                end
            end
            PH_EXT16:
            begin
                len_next     = {{(LEN_W-16){1'b0}}, len_reg[7:0], data_byte};
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                after_len    = (hdr_cnt_reg == 3'd1);
            end
            PH_EXT64:
            begin
                len_next     = {len_reg[LEN_W-9:0], data_byte};
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                after_len    = (hdr_cnt_reg == 3'd7);
            end
            PH_KEY:
            begin
                key_next     = {key_reg[23:0], data_byte};
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                finish       = (hdr_cnt_reg == 3'd3);
            end
            PH_PAYLOAD:
            begin
                emit         = 1'b1;
                obyte        = data_byte ^ key_byte;
                lst          = (remain_reg[LEN_W-1:1] == '0);
                key_idx_next = key_idx_reg + 2'd1;
                if (lst)
                begin
                    remain_next = '0;
                    phase_next  = PH_BYTE0;
                end
                else
                begin
                    remain_next = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                phase_next = PH_BYTE0;
            end
        endcase

        if (after_len)
        begin
            hdr_cnt_next = 3'd0;
            if (mask_next)
            begin
                phase_next = PH_KEY;
            end
            else
            begin
                finish = 1'b1;
            end
        end

        if (finish)
        begin
            hdr_cnt_next = 3'd0;
            key_idx_next = 2'd0;
            remain_next  = len_next;
            emit         = 1'b1;
            hdr          = 1'b1;
            lst          = (len_next == '0);
            phase_next   = lst ? PH_BYTE0 : PH_PAYLOAD;
        end
    end

    assign res_valid       = step && emit;
    assign res.is_header   = hdr;
    assign res.fin         = fin_next;
    assign res.opcode      = opcode_next;
    assign res.masked      = mask_next;
    assign res.body_length = len_next;
    assign res.out_byte    = obyte;
    assign res.last        = lst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BYTE0;
            hdr_cnt_reg <= 3'd0;
            fin_reg     <= 1'b0;
            opcode_reg  <= 4'd0;
            mask_reg    <= 1'b0;
            len_reg     <= '0;
            key_reg     <= 32'd0;
            key_idx_reg <= 2'd0;
            remain_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            key_idx_reg <= key_idx_next;
            remain_reg  <= remain_next;
        end
    end
endmodule

/* rtl/wsd_out_stage.sv */
// Result register of the deframer: holds one result until the sink takes it.
// Depends on wsd_pkg and wsd_out_if.
module wsd_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_valid,
    input  wsd_pkg::res_t load_res,
    output logic          load_ready,
    wsd_out_if.source     result_ch
);
    import wsd_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign load_ready = !valid_reg || result_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            res_reg <= load_res;
        end
    end

    assign result_ch.valid       = valid_reg;
    assign result_ch.is_header   = res_reg.is_header;
    assign result_ch.fin         = res_reg.fin;
    assign result_ch.opcode      = res_reg.opcode;
    assign result_ch.masked      = res_reg.masked;
    assign result_ch.body_length = res_reg.body_length;
    assign result_ch.out_byte    = res_reg.out_byte;
    assign result_ch.last        = res_reg.last;
endmodule

/* rtl/wsd_checker.sv */
// Port-level checker of the deframer's result stream, bound to the top level.
// Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      valid,
    input logic                      ready,
    input logic                      is_header,
    input logic                      last,
    input logic [7:0]                out_byte,
    input logic [wsd_pkg::LEN_W-1:0] body_length
);
    import wsd_pkg::*;

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [LEN_W-1:0] hdr_len_reg;
    logic             out_acc;
    logic             hdr_ok;

    assign out_acc = valid && ready;
    assign hdr_ok  = (out_byte == 8'd0) && (last == (body_length == '0));

    always_comb
    begin
        in_frame_next = in_frame_reg;
        if (out_acc)
        begin
            in_frame_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            hdr_len_reg  <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            if (out_acc && is_header)
            begin
                hdr_len_reg <= body_length;
            end
        end
    end

    `WSD_ASSERT_HOLD(a_stall_hold, clk, rst_n, valid && !ready, {valid, is_header, out_byte, last, body_length})
    `WSD_ASSERT(a_header_starts_frame, clk, rst_n, out_acc && is_header |-> !in_frame_reg)
    `WSD_ASSERT(a_payload_in_frame, clk, rst_n, out_acc && !is_header |-> in_frame_reg && body_length == hdr_len_reg)
    `WSD_ASSERT(a_header_shape, clk, rst_n, valid && is_header |-> hdr_ok)
endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result_ch.valid),
    .ready       (result_ch.ready),
    .is_header   (result_ch.is_header),
    .last        (result_ch.last),
    .out_byte    (result_ch.out_byte),
    .body_length (result_ch.body_length)
);

/* test/deframe_check.sv */
`timescale 1ns / 1ps
// Checker of the WebSocket frame deframer: follows every accepted byte request, works out the
// header and payload results it causes and compares them with the result requests seen.
// Depends on wsd_pkg and on the channel interfaces of wsd_intf.
module deframe_check (
    input  logic        clk,
    input  logic        rst_n,
    wsd_in_if           byte_ch,
    wsd_out_if.monitor  result_ch,
    output int unsigned fail_count,
    output int unsigned pending
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        HDR_OPCODE,
        HDR_LENGTH,
        HDR_EXT16,
        HDR_EXT64,
        HDR_KEY,
        PAYLOAD
    } parse_state_t;

    localparam int unsigned REPORT_MAX = 10;

    parse_state_t pstate;
    logic [3:0]   hdr_count;
    logic         fin_q;
    logic [3:0]   opcode_q;
    logic         mask_q;
    logic [63:0]  length_q;
    logic [31:0]  key_q;
    logic [1:0]   key_pos;
    logic [63:0]  remaining;
    res_t         results_due[$];
    int unsigned  errors;

    function automatic void queue_result(logic hdr, logic [7:0] value, logic lst);
        res_t r;
        r.is_header   = hdr;
        r.fin         = fin_q;
        r.opcode      = opcode_q;
        r.masked      = mask_q;
        r.body_length = length_q[LEN_W-1:0];
        r.out_byte    = value;
        r.last        = lst;
        results_due.push_back(r);
    endfunction

    function automatic void close_header();
        length_q[63] = 1'b0;
        hdr_count    = '0;
        key_pos      = '0;
        remaining    = length_q;
        if (length_q == 64'd0)
        begin
            pstate = HDR_OPCODE;
            queue_result(1'b1, 8'h00, 1'b1);
        end
        else
        begin
            pstate = PAYLOAD;
            queue_result(1'b1, 8'h00, 1'b0);
        end
    endfunction

    function automatic void length_known();
        hdr_count = '0;
        if (mask_q)
            pstate = HDR_KEY;
        else
            close_header();
    endfunction

    function automatic void report_error(string what, res_t want, res_t seen);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%0t %s: expected hdr %0b fin %0b op %h mask %0b len %0d byte %h last %0b",
                     $time, what, want.is_header, want.fin, want.opcode, want.masked,
                     want.body_length, want.out_byte, want.last,
                     ", got hdr %0b fin %0b op %h mask %0b len %0d byte %h last %0b",
                     seen.is_header, seen.fin, seen.opcode, seen.masked,
                     seen.body_length, seen.out_byte, seen.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] b;
        logic       lst;
        res_t       seen;
        res_t       want;
        if (!rst_n)
        begin
            pstate    = HDR_OPCODE;
            hdr_count = '0;
            fin_q     = 1'b0;
            opcode_q  = '0;
            mask_q    = 1'b0;
            length_q  = '0;
            key_q     = '0;
            key_pos   = '0;
            remaining = '0;
            errors    = 0;
            results_due.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                b = byte_ch.data_byte;
                case (pstate)
                    HDR_OPCODE:
                    begin
                        fin_q    = b[7];
                        opcode_q = b[3:0];
                        pstate   = HDR_LENGTH;
                    end
                    HDR_LENGTH:
                    begin
                        mask_q    = b[7];
                        length_q  = {57'd0, b[6:0]};
                        key_q     = '0;
                        hdr_count = '0;
                        if (b[6:0] == LEN_CODE_EXT16)
                        begin
                            length_q = '0;
                            pstate   = HDR_EXT16;
                        end
                        else if (b[6:0] == LEN_CODE_EXT64)
                        begin
                            length_q = '0;
                            pstate   = HDR_EXT64;
                        end
                        else
                            length_known();
                    end
                    HDR_EXT16:
                    begin
                        length_q  = {48'd0, length_q[7:0], b};
                        hdr_count = hdr_count + 4'd1;
                        if (hdr_count >= 4'd2)
                            length_known();
                    end
                    HDR_EXT64:
                    begin
                        length_q  = {length_q[55:0], b};
                        hdr_count = hdr_count + 4'd1;
                        if (hdr_count >= 4'd8)
                            length_known();
                    end
                    HDR_KEY:
                    begin
                        key_q     = {key_q[23:0], b};
                        hdr_count = hdr_count + 4'd1;
                        if (hdr_count >= 4'd4)
                            close_header();
                    end
                    PAYLOAD:
                    begin
                        lst = (remaining <= 64'd1);
                        queue_result(1'b0, b ^ key_q[8*(3-key_pos) +: 8], lst);
                        key_pos = key_pos + 2'd1;
                        if (lst)
                        begin
                            remaining = '0;
                            pstate    = HDR_OPCODE;
                        end
                        else
                            remaining = remaining - 64'd1;
                    end
                    default:
                        pstate = HDR_OPCODE;
                endcase
            end

            if (result_ch.valid && result_ch.ready)
            begin
                seen.is_header   = result_ch.is_header;
                seen.fin         = result_ch.fin;
                seen.opcode      = result_ch.opcode;
                seen.masked      = result_ch.masked;
                seen.body_length = result_ch.body_length;
                seen.out_byte    = result_ch.out_byte;
                seen.last        = result_ch.last;
                if (results_due.size() == 0)
                    report_error("unexpected result", '0, seen);
                else
                begin
                    want = results_due.pop_front();
                    if ((seen.is_header !== want.is_header) || (seen.fin !== want.fin) ||
                        (seen.opcode !== want.opcode) || (seen.masked !== want.masked) ||
                        (seen.body_length !== want.body_length) ||
                        (seen.out_byte !== want.out_byte) || (seen.last !== want.last))
                        report_error("mismatch", want, seen);
                end
            end

            fail_count <= errors;
            pending    <= results_due.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte requests built as WebSocket frames and
// random stalls on the result channel, with the verdict at the end.
// Depends on wsd_pkg, wsd_intf, the deframer core and deframe_check.
module tb;
    import wsd_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1450;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned IDLE_PCT     = 38;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    bit          steady = 1'b0;
    int unsigned sent = 0;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned pending;

    wsd_in_if  byte_ch();
    wsd_out_if result_ch();

    websocket_frame_deframer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    deframe_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .result_ch  (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    task automatic push_byte(input logic [7:0] value);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= value;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sent++;
        steady = (sent >= 500 && sent < 700);
    endtask

    task automatic send_frame(input logic [7:0] lead, input logic [7:0] code_byte,
                              input logic [63:0] ext_len, input logic [31:0] key,
                              input int unsigned body);
        push_byte(lead);
        push_byte(code_byte);
        if (code_byte[6:0] == LEN_CODE_EXT16)
            for (int i = 1; i >= 0; i--)
                push_byte(ext_len[8*i +: 8]);
        else if (code_byte[6:0] == LEN_CODE_EXT64)
            for (int i = 7; i >= 0; i--)
                push_byte(ext_len[8*i +: 8]);
        if (code_byte[7])
            for (int i = 3; i >= 0; i--)
                push_byte(key[8*i +: 8]);
        repeat (body)
            push_byte(8'($urandom_range(255)));
    endtask

    task automatic settle();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0]  lead;
        logic [7:0]  code_byte;
        logic [63:0] ext_len;
        logic [62:0] frame_len;
        int unsigned pick;
        bit          paused;
        paused = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        result_ch.ready   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Masked empty frame, then an empty frame whose 64-bit length has only its top bit set.
        send_frame(8'h89, 8'h80, 64'd0, 32'hFFFF_FFFF, 0);
        send_frame(8'h0A, 8'h7F, 64'h8000_0000_0000_0000, 32'd0, 0);
        // Non-minimal 16-bit length with reserved bits set, and a masked frame whose key wraps.
        send_frame(8'hF2, 8'h7E, 64'd1, 32'd0, 1);
        send_frame(8'h8F, 8'h85, 64'd0, 32'hA53C_0FF0, 5);

        while (sent < ITEM_TARGET)
        begin
            if (!paused && sent >= ITEM_TARGET / 2)
            begin
                settle();
                paused = 1'b1;
            end
            lead = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 10)
                code_byte = 8'($urandom_range(255));
            else if (pick < 70)
                code_byte = {1'($urandom_range(1)),
                             ($urandom_range(99) < 80) ? 7'($urandom_range(12))
                                                       : 7'($urandom_range(125, 13))};
            else if (pick < 85)
                code_byte = {1'($urandom_range(1)), LEN_CODE_EXT16};
            else
                code_byte = {1'($urandom_range(1)), LEN_CODE_EXT64};
            ext_len = ($urandom_range(99) < 85) ? 64'($urandom_range(20))
                                                : 64'($urandom_range(300));
            ext_len[63] = 1'($urandom_range(1));
            if (code_byte[6:0] == LEN_CODE_EXT16)
                frame_len = 63'(ext_len[15:0]);
            else if (code_byte[6:0] == LEN_CODE_EXT64)
                frame_len = ext_len[62:0];
            else
                frame_len = 63'(code_byte[6:0]);
            send_frame(lead, code_byte, ext_len, $urandom(), int'(frame_len));
        end

        // A frame of the greatest length ends the run, so that every length bit is seen set.
        send_frame(8'h82, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, $urandom(), 20);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
